/* src/fdat_pkg.sv */
// shared types and constants for the fixed-degree adjacency table
// no dependencies
`default_nettype none
package fdat_pkg;
   localparam int NODE_COUNT_DEF = 1024;
   localparam int ROW_SLOTS_DEF  = 32;
   localparam int ID_BITS_DEF    = 16;

   localparam logic [2:0] OP_ADD      = 3'd0;
   localparam logic [2:0] OP_REMOVE   = 3'd1;
   localparam logic [2:0] OP_CLEAR    = 3'd2;
   localparam logic [2:0] OP_APPEND   = 3'd3;
   localparam logic [2:0] OP_READ     = 3'd4;
   localparam logic [2:0] OP_DEGREE   = 3'd5;
   // spare codes, handled as read degree
   localparam logic [2:0] OP_SPARE_LO = 3'd6;
   localparam logic [2:0] OP_SPARE_HI = 3'd7;

   localparam logic [2:0] ST_OK        = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_EXISTS    = 3'd2;
   localparam logic [2:0] ST_FULL      = 3'd3;
   localparam logic [2:0] ST_NOT_FOUND = 3'd4;
   localparam logic [2:0] ST_TOO_MANY  = 3'd5;

   localparam logic [15:0] EMPTY_MARK = 16'hFFFF;

   localparam logic [10:0] NODES_RESET = 11'd1024;
   localparam logic [5:0]  LIMIT_RESET = 6'd32;

   localparam logic CSR_NODES = 1'b0;
   localparam logic CSR_LIMIT = 1'b1;

   typedef struct packed {
      logic [2:0]  op;
      logic [15:0] node;
      logic [15:0] other_node;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [6:0]  row_degree_out;
      logic [15:0] neighbor_id;
      logic [5:0]  slot;
      logic [15:0] edge_count;
      logic        last;
   } rsp_type;

   // classified command from the front to the back
   typedef struct packed {
      logic [2:0]  op;
      logic        bad;
      logic [15:0] node;
      logic [15:0] other_node;
   } cmd_type;
endpackage
`default_nettype wire

/* src/fdat_ram.sv */
// generic single-port-write, one-read ram with registered read data
// no dependencies
`default_nettype none
module fdat_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32768
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule
`default_nettype wire

/* src/fdat_front.sv */
// front: range check and a two-entry command queue
// depends on fdat_pkg
`default_nettype none
module fdat_front #(
   parameter int NODE_COUNT = fdat_pkg::NODE_COUNT_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fdat_pkg::req_type req_data,
   input  wire logic [10:0]       nodes_in_use,
   output logic                   cmd_valid,
   input  wire logic              cmd_ready,
   output fdat_pkg::cmd_type      cmd_data
);
   localparam int NB = $clog2(NODE_COUNT + 1) > 11 ? $clog2(NODE_COUNT + 1) : 11;
   localparam logic [NB-1:0] NN = NB'(NODE_COUNT);

   fdat_pkg::cmd_type q_ff [2];
   fdat_pkg::cmd_type q_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [NB-1:0] lim;
   logic push, pop;

   always_comb begin
      lim = (NB'(nodes_in_use) < NN) ? NB'(nodes_in_use) : NN;
      q_in.op = req_data.op;
      q_in.node = req_data.node;
      q_in.other_node = req_data.other_node;
      q_in.bad = (NB'(req_data.node) >= lim) ||
                 ({1'b0, req_data.node} >= 17'(lim)) ||
                 (((req_data.op == fdat_pkg::OP_ADD) ||
                   (req_data.op == fdat_pkg::OP_REMOVE)) &&
                  ({1'b0, req_data.other_node} >= 17'(lim)));
      req_ready = cnt_ff != 2'd2;
      cmd_valid = cnt_ff != 2'd0;
      cmd_data  = q_ff[rp_ff];
      push = req_valid && req_ready;
      pop  = cmd_valid && cmd_ready;
      wp_in = push ? ~wp_ff : wp_ff;
      rp_in = pop ? ~rp_ff : rp_ff;
      cnt_in = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= q_in;
      end
      if (reset) begin
         cnt_ff <= 2'd0;
         wp_ff <= 1'b0;
         rp_ff <= 1'b0;
      end else begin
         cnt_ff <= cnt_in;
         wp_ff <= wp_in;
         rp_ff <= rp_in;
      end
   end
endmodule
`default_nettype wire

/* src/fdat_back.sv */
// back: sequencer that walks at most one row of the neighbor ram per command
// depends on fdat_pkg and fdat_ram
`default_nettype none
module fdat_back #(
   parameter int NODE_COUNT = fdat_pkg::NODE_COUNT_DEF,
   parameter int ROW_SLOTS  = fdat_pkg::ROW_SLOTS_DEF,
   parameter int ID_BITS    = fdat_pkg::ID_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              cmd_valid,
   output logic                   cmd_ready,
   input  wire fdat_pkg::cmd_type cmd_data,
   input  wire logic [5:0]        degree_limit,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fdat_pkg::rsp_type      rsp_data
);
   localparam int NODE_W = $clog2(NODE_COUNT);
   localparam int SLOT_W = (ROW_SLOTS > 1) ? $clog2(ROW_SLOTS) : 1;
   localparam int DEG_W  = $clog2(ROW_SLOTS + 1);
   localparam int ADDR_W = $clog2(NODE_COUNT * ROW_SLOTS);
   localparam int DEPTH  = NODE_COUNT * ROW_SLOTS;
   localparam int CLR_W  = $clog2(NODE_COUNT + 1);
   localparam int SW     = (SLOT_W > DEG_W) ? SLOT_W : DEG_W;
   localparam logic [DEG_W-1:0] MAXD = DEG_W'(ROW_SLOTS);

   localparam logic [2:0] S_CLR  = 3'd0;
   localparam logic [2:0] S_IDLE = 3'd1;
   localparam logic [2:0] S_DEG  = 3'd2;
   localparam logic [2:0] S_SCAN = 3'd3;
   localparam logic [2:0] S_SHFT = 3'd4;
   localparam logic [2:0] S_READ = 3'd5;
   localparam logic [2:0] S_FIN  = 3'd6;

   logic [2:0] st_ff, st_in;
   fdat_pkg::cmd_type c_ff, c_in;
   logic [DEG_W-1:0] deg_ff, deg_in;
   logic [SW:0] i_ff, i_in;
   logic [CLR_W-1:0] clr_ff, clr_in;
   logic [15:0] tot_ff, tot_in;
   logic [2:0] sts_ff, sts_in;
   logic rv_ff, rv_in;
   fdat_pkg::rsp_type r_ff, r_in;
   logic found_ff, found_in;

   logic dwe; logic [NODE_W-1:0] dwa, dra; logic [DEG_W-1:0] dwd, drd;
   logic nwe; logic [ADDR_W-1:0] nwa, nra; logic [15:0] nwd, nrd;
   logic [DEG_W-1:0] cap;
   logic [NODE_W-1:0] nd;
   logic [ADDR_W-1:0] base;
   logic [ID_BITS-1:0] oid;
   logic out_free;

   fdat_ram #(.WIDTH(DEG_W), .DEPTH(NODE_COUNT)) u_deg (
      .clock, .wr_en(dwe), .wr_addr(dwa), .wr_data(dwd), .rd_addr(dra), .rd_data(drd));
   fdat_ram #(.WIDTH(16), .DEPTH(DEPTH)) u_nbr (
      .clock, .wr_en(nwe), .wr_addr(nwa), .wr_data(nwd), .rd_addr(nra), .rd_data(nrd));

   always_comb begin
      nd   = c_ff.node[NODE_W-1:0];
      base = ADDR_W'(nd) * ADDR_W'(ROW_SLOTS);
      oid  = ID_BITS'(c_ff.other_node);
      cap  = (DEG_W'(degree_limit) < MAXD && {1'b0, degree_limit} < 7'(ROW_SLOTS))
             ? DEG_W'(degree_limit) : MAXD;
      out_free = !rv_ff || rsp_ready;
      st_in = st_ff; c_in = c_ff; deg_in = deg_ff; i_in = i_ff; clr_in = clr_ff;
      tot_in = tot_ff; sts_in = sts_ff; found_in = found_ff;
      rv_in = rv_ff && !rsp_ready; r_in = r_ff;
      cmd_ready = 1'b0;
      dwe = 1'b0; dwa = nd; dwd = deg_ff; dra = cmd_data.node[NODE_W-1:0];
      nwe = 1'b0; nwa = base + ADDR_W'(i_ff); nwd = 16'(oid);
      nra = base + ADDR_W'(i_ff);
      case (st_ff)
         S_CLR: begin
            dwe = 1'b1; dwa = clr_ff[NODE_W-1:0]; dwd = '0;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == CLR_W'(NODE_COUNT - 1)) st_in = S_IDLE;
         end
         S_IDLE: begin
            if (cmd_valid && out_free) begin
               cmd_ready = 1'b1;
               c_in = cmd_data;
               if (cmd_data.bad) begin
                  rv_in = 1'b1;
                  r_in = '{fdat_pkg::ST_RANGE, 7'd0, fdat_pkg::EMPTY_MARK, 6'd0,
                           tot_ff, 1'b1};
               end else begin
                  st_in = S_DEG;
               end
            end
         end
         S_DEG: begin
            deg_in = (drd > MAXD) ? MAXD : drd;
            i_in = '0; found_in = 1'b0; sts_in = fdat_pkg::ST_OK;
            case (c_ff.op)
               fdat_pkg::OP_ADD, fdat_pkg::OP_REMOVE: st_in = S_SCAN;
               fdat_pkg::OP_READ: st_in = S_READ;
               default: st_in = S_FIN;
            endcase
         end
         S_SCAN: begin
            // one address per cycle; data for slot i-1 arrives now
            if (i_ff != '0 && 16'(nrd) == 16'(oid)) begin
               found_in = 1'b1;
               i_in = i_ff - 1'b1;
               if (c_ff.op == fdat_pkg::OP_ADD) begin
                  sts_in = fdat_pkg::ST_EXISTS; st_in = S_FIN;
               end else begin
                  st_in = S_SHFT; i_in = i_ff;
               end
            end else if (i_ff >= (SW+1)'(deg_ff)) begin
               st_in = S_FIN;
            end else begin
               i_in = i_ff + 1'b1;
            end
         end
         S_SHFT: begin
            // nra reads slot i, written to slot i-1 next cycle
            if (found_ff) begin
               found_in = 1'b0;
               i_in = i_ff;
            end else begin
               nwe = (i_ff < (SW+1)'(deg_ff));
               nwa = base + ADDR_W'(i_ff - 1'b1); nwd = nrd;
               nra = base + ADDR_W'(i_ff + 1'b1);
               i_in = i_ff + 1'b1;
            end
            if (!found_ff && i_ff >= (SW+1)'(deg_ff)) begin
               found_in = 1'b1; st_in = S_FIN;
            end
         end
         S_READ: begin
            if (i_ff != '0 && out_free) begin
               rv_in = 1'b1;
               r_in = '{fdat_pkg::ST_OK, 7'(deg_ff),
                        ((i_ff - 1'b1) < (SW+1)'(deg_ff)) ? nrd : fdat_pkg::EMPTY_MARK,
                        6'(i_ff - 1'b1), tot_ff, (i_ff == (SW+1)'(ROW_SLOTS))};
            end
            if (i_ff == '0 || out_free) begin
               if (i_ff == (SW+1)'(ROW_SLOTS)) st_in = S_IDLE;
               else begin
                  i_in = i_ff + 1'b1;
                  nra = base + ADDR_W'(i_ff);
               end
            end else begin
               nra = base + ADDR_W'(i_ff - 1'b1);
            end
         end
         S_FIN: begin
            if (out_free) begin
               case (c_ff.op)
                  fdat_pkg::OP_ADD: begin
                     if (sts_ff == fdat_pkg::ST_OK) begin
                        if (deg_ff < cap) begin
                           nwe = 1'b1; nwa = base + ADDR_W'(deg_ff);
                           deg_in = deg_ff + 1'b1;
                           if (tot_ff != 16'hFFFF) tot_in = tot_ff + 1'b1;
                        end else sts_in = fdat_pkg::ST_FULL;
                     end
                  end
                  fdat_pkg::OP_REMOVE: begin
                     if (found_ff) begin
                        deg_in = deg_ff - 1'b1;
                        if (tot_ff != '0) tot_in = tot_ff - 1'b1;
                     end else sts_in = fdat_pkg::ST_NOT_FOUND;
                  end
                  fdat_pkg::OP_CLEAR: deg_in = '0;
                  fdat_pkg::OP_APPEND: begin
                     if (deg_ff < cap) begin
                        nwe = 1'b1; nwa = base + ADDR_W'(deg_ff);
                        deg_in = deg_ff + 1'b1;
                     end else sts_in = fdat_pkg::ST_TOO_MANY;
                  end
                  default: ;
               endcase
               dwe = 1'b1; dwd = deg_in;
               rv_in = 1'b1;
               r_in = '{sts_in, 7'(deg_in), fdat_pkg::EMPTY_MARK, 6'd0, tot_in, 1'b1};
               st_in = S_IDLE;
            end
         end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      c_ff <= c_in; deg_ff <= deg_in; i_ff <= i_in; sts_ff <= sts_in;
      r_ff <= r_in; found_ff <= found_in;
      if (reset) begin
         st_ff <= S_CLR; clr_ff <= '0; tot_ff <= '0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; clr_ff <= clr_in; tot_ff <= tot_in; rv_ff <= rv_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_data  = r_ff;
endmodule
`default_nettype wire

/* src/fixed_degree_adjacency_table.sv */
// top level of the fixed-degree adjacency table: csr port, front, back
// depends on fdat_pkg, fdat_front, fdat_back
//
// The back sequencer walks the neighbor ram one slot per cycle, pausing a row read
// while a response is stalled: a duplicate search scans the row, a removal also
// compacts it, a row read gives one response per slot and an out-of-range request
// is answered from the idle state without a walk. After reset a clearing pass
// zeroes the degree ram; up to two requests queue in the front meanwhile.
`default_nettype none
module fixed_degree_adjacency_table #(
   parameter int NODE_COUNT = fdat_pkg::NODE_COUNT_DEF,
   parameter int ROW_SLOTS  = fdat_pkg::ROW_SLOTS_DEF,
   parameter int ID_BITS    = fdat_pkg::ID_BITS_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire fdat_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output fdat_pkg::rsp_type      rsp_data,
   input  wire logic              psel,
   input  wire logic              penable,
   input  wire logic              pwrite,
   input  wire logic [2:0]        paddr,
   input  wire logic [31:0]       pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);
   logic [10:0] nodes_ff;
   logic [5:0]  limit_ff;
   logic cmd_valid, cmd_ready;
   fdat_pkg::cmd_type cmd_data;
   logic wr;

   assign pready = 1'b1;
   assign wr = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         nodes_ff <= fdat_pkg::NODES_RESET;
         limit_ff <= fdat_pkg::LIMIT_RESET;
      end else if (wr && paddr[1:0] == 2'd0) begin
         if (paddr[2] == fdat_pkg::CSR_NODES) nodes_ff <= pwdata[10:0];
         else limit_ff <= pwdata[5:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[1:0] == 2'd0) begin
         if (paddr[2] == fdat_pkg::CSR_NODES) prdata = {21'd0, nodes_ff};
         else prdata = {26'd0, limit_ff};
      end
   end

   fdat_front #(.NODE_COUNT(NODE_COUNT)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .nodes_in_use(nodes_ff), .cmd_valid, .cmd_ready, .cmd_data);

   fdat_back #(
      .NODE_COUNT(NODE_COUNT), .ROW_SLOTS(ROW_SLOTS), .ID_BITS(ID_BITS)
   ) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .degree_limit(limit_ff), .rsp_valid, .rsp_ready, .rsp_data);
endmodule
`default_nettype wire

/* src/fdat_checker.sv */
// port-level checks for the adjacency table, bound to the top level
// depends on fdat_pkg and fixed_degree_adjacency_table
`default_nettype none
module fdat_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire fdat_pkg::rsp_type rsp_data,
   input wire logic              pready
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data)) else $error("rsp hold");
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.status == fdat_pkg::ST_RANGE |->
      rsp_data.row_degree_out == 7'd0 && rsp_data.last) else $error("range rsp");
   a_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.last |-> rsp_data.status == fdat_pkg::ST_OK)
      else $error("row read status");
   a_pready: assert property (@(posedge clock) pready) else $error("pready");
endmodule

bind fixed_degree_adjacency_table fdat_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_data, .pready);
`default_nettype wire

/* dv/fixed_degree_adjacency_table_tb.sv */
// self-checking testbench for the fixed-degree adjacency table
// depends on fdat_pkg and fixed_degree_adjacency_table; holds its own graph predictor
`timescale 1ns / 1ps
module fixed_degree_adjacency_table_tb;
   localparam int NODES = fdat_pkg::NODE_COUNT_DEF;
   localparam int DEG_MAX = fdat_pkg::ROW_SLOTS_DEF;
   localparam int CYCLE_LIMIT = 1000000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   fdat_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   fdat_pkg::rsp_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [2:0] paddr = '0;
   logic [31:0] pwdata = '0;
   logic [31:0] prdata;
   logic pready;

   // graph predictor state
   logic [15:0] row_mem [0:NODES*DEG_MAX-1];
   int node_deg [0:NODES-1];
   int edge_total;
   int nodes_cfg;
   int limit_cfg;
   fdat_pkg::rsp_type pending_rsp [$];

   int errors = 0;
   int cycles = 0;
   bit quiet = 1'b0;
   int rsp_wait = 0;

   fixed_degree_adjacency_table DUT (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   task automatic push_rsp(input logic [2:0] st, input int deg, input logic [15:0] nb,
                           input int sl, input bit fin);
      fdat_pkg::rsp_type e;
      e.status = st;
      e.row_degree_out = deg[6:0];
      e.neighbor_id = nb;
      e.slot = sl[5:0];
      e.edge_count = edge_total[15:0];
      e.last = fin;
      pending_rsp.push_back(e);
   endtask

   task automatic apply_request(input fdat_pkg::req_type r);
      int lim, cap, deg, hit, base;
      logic [2:0] st;
      lim = nodes_cfg < NODES ? nodes_cfg : NODES;
      cap = limit_cfg < DEG_MAX ? limit_cfg : DEG_MAX;
      st = fdat_pkg::ST_OK;
      if (r.node >= lim || ((r.op == fdat_pkg::OP_ADD || r.op == fdat_pkg::OP_REMOVE) &&
                            r.other_node >= lim)) begin
         push_rsp(fdat_pkg::ST_RANGE, 0, fdat_pkg::EMPTY_MARK, 0, 1'b1);
         return;
      end
      base = r.node * DEG_MAX;
      deg = node_deg[r.node];
      hit = -1;
      for (int i = 0; i < deg; i++)
         if (hit < 0 && row_mem[base+i] == r.other_node) hit = i;
      case (r.op)
         fdat_pkg::OP_ADD: begin
            if (hit >= 0) st = fdat_pkg::ST_EXISTS;
            else if (deg < cap) begin
               row_mem[base+deg] = r.other_node;
               deg++;
               if (edge_total < 65535) edge_total++;
            end else st = fdat_pkg::ST_FULL;
         end
         fdat_pkg::OP_REMOVE: begin
            if (hit >= 0) begin
               for (int j = hit; j + 1 < deg; j++) row_mem[base+j] = row_mem[base+j+1];
               deg--;
               if (edge_total > 0) edge_total--;
            end else st = fdat_pkg::ST_NOT_FOUND;
         end
         fdat_pkg::OP_CLEAR: deg = 0;
         fdat_pkg::OP_APPEND: begin
            if (deg < cap) begin
               row_mem[base+deg] = r.other_node;
               deg++;
            end else st = fdat_pkg::ST_TOO_MANY;
         end
         fdat_pkg::OP_READ: begin
            for (int i = 0; i < DEG_MAX; i++)
               push_rsp(fdat_pkg::ST_OK, deg,
                        i < deg ? row_mem[base+i] : fdat_pkg::EMPTY_MARK, i,
                        i == DEG_MAX - 1);
            return;
         end
         default: ;
      endcase
      node_deg[r.node] = deg;
      push_rsp(st, deg, fdat_pkg::EMPTY_MARK, 0, 1'b1);
   endtask

   // response side: random stalls and field compare
   always @(posedge clock) begin
      if (rsp_valid && rsp_ready) begin
         if (pending_rsp.size() == 0) begin
            $error("unexpected response %p", rsp_data);
            errors++;
         end else begin
            fdat_pkg::rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.status !== e.status) begin
               $error("status exp %0d got %0d", e.status, rsp_data.status); errors++;
            end
            if (rsp_data.row_degree_out !== e.row_degree_out) begin
               $error("row_degree_out exp %0d got %0d", e.row_degree_out,
                      rsp_data.row_degree_out); errors++;
            end
            if (rsp_data.neighbor_id !== e.neighbor_id) begin
               $error("neighbor_id exp %0d got %0d", e.neighbor_id, rsp_data.neighbor_id);
               errors++;
            end
            if (rsp_data.slot !== e.slot) begin
               $error("slot exp %0d got %0d", e.slot, rsp_data.slot); errors++;
            end
            if (rsp_data.edge_count !== e.edge_count) begin
               $error("edge_count exp %0d got %0d", e.edge_count, rsp_data.edge_count);
               errors++;
            end
            if (rsp_data.last !== e.last) begin
               $error("last exp %0d got %0d", e.last, rsp_data.last); errors++;
            end
         end
         rsp_wait = quiet ? 0 : $urandom_range(0, 10);
         rsp_ready <= (rsp_wait == 0);
      end else if (!rsp_ready) begin
         if (rsp_wait > 0) rsp_wait--;
         rsp_ready <= (rsp_wait == 0);
      end
   end

   task automatic send_request(input logic [2:0] op, input int node, input int other);
      fdat_pkg::req_type r;
      int gap;
      r.op = op;
      r.node = node[15:0];
      r.other_node = other[15:0];
      gap = quiet ? 0 : $urandom_range(0, 10);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
      apply_request(r);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input int value);
      wait_idle();
      psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
      if (addr[2] == fdat_pkg::CSR_NODES) nodes_cfg = value & 'h7FF;
      else limit_cfg = value & 'h3F;
   endtask

   task automatic set_nodes(input int v);
      csr_write({fdat_pkg::CSR_NODES, 2'b00}, v);
   endtask

   task automatic set_limit(input int v);
      csr_write({fdat_pkg::CSR_LIMIT, 2'b00}, v);
   endtask

   task automatic test_directed_ops();
      send_request(fdat_pkg::OP_DEGREE, 0, 0);
      send_request(fdat_pkg::OP_ADD, 0, 1);
      send_request(fdat_pkg::OP_ADD, 0, 1);
      send_request(fdat_pkg::OP_ADD, 0, 1023);
      send_request(fdat_pkg::OP_ADD, 1023, 0);
      send_request(fdat_pkg::OP_ADD, 1024, 0);
      send_request(fdat_pkg::OP_ADD, 0, 1024);
      send_request(fdat_pkg::OP_ADD, 65535, 65535);
      send_request(fdat_pkg::OP_REMOVE, 0, 7);
      send_request(fdat_pkg::OP_REMOVE, 0, 65535);
      send_request(fdat_pkg::OP_REMOVE, 0, 1);
      send_request(fdat_pkg::OP_REMOVE, 0, 1023);
      send_request(fdat_pkg::OP_APPEND, 0, 65535);
      send_request(fdat_pkg::OP_APPEND, 0, 0);
      send_request(fdat_pkg::OP_READ, 0, 0);
      send_request(fdat_pkg::OP_REMOVE, 0, 0);
      send_request(fdat_pkg::OP_APPEND, 0, 5);
      send_request(fdat_pkg::OP_REMOVE, 0, 5);
      send_request(fdat_pkg::OP_CLEAR, 1023, 0);
      send_request(fdat_pkg::OP_SPARE_LO, 0, 0);
      send_request(fdat_pkg::OP_SPARE_HI, 0, 0);
      send_request(fdat_pkg::OP_READ, 1023, 0);
      send_request(fdat_pkg::OP_READ, 1024, 0);
      send_request(fdat_pkg::OP_CLEAR, 0, 0);
   endtask

   task automatic test_degree_limit();
      set_limit(1);
      send_request(fdat_pkg::OP_ADD, 2, 3);
      send_request(fdat_pkg::OP_ADD, 2, 4);
      send_request(fdat_pkg::OP_APPEND, 2, 4);
      set_limit(63);
      for (int i = 0; i < DEG_MAX; i++) send_request(fdat_pkg::OP_ADD, 3, 40 + i);
      send_request(fdat_pkg::OP_ADD, 3, 7);
      send_request(fdat_pkg::OP_APPEND, 3, 7);
      send_request(fdat_pkg::OP_READ, 3, 0);
      set_limit(4);
      send_request(fdat_pkg::OP_ADD, 3, 8);
      send_request(fdat_pkg::OP_REMOVE, 3, 40);
      send_request(fdat_pkg::OP_APPEND, 3, 9);
      send_request(fdat_pkg::OP_READ, 3, 0);
      set_limit(0);
      send_request(fdat_pkg::OP_ADD, 5, 1);
      send_request(fdat_pkg::OP_APPEND, 5, 1);
      set_limit(32);
   endtask

   task automatic test_node_count();
      set_nodes(1);
      send_request(fdat_pkg::OP_ADD, 0, 0);
      send_request(fdat_pkg::OP_ADD, 0, 1);
      send_request(fdat_pkg::OP_READ, 1, 0);
      set_nodes(0);
      send_request(fdat_pkg::OP_DEGREE, 0, 0);
      send_request(fdat_pkg::OP_APPEND, 0, 3);
      set_nodes(2047);
      send_request(fdat_pkg::OP_ADD, 1023, 1023);
      send_request(fdat_pkg::OP_ADD, 1024, 1);
      set_nodes(1024);
   endtask

   task automatic random_request();
      int pick, node, other;
      logic [2:0] op;
      pick = $urandom_range(0, 99);
      if (pick < 30) op = fdat_pkg::OP_ADD;
      else if (pick < 50) op = fdat_pkg::OP_REMOVE;
      else if (pick < 66) op = fdat_pkg::OP_APPEND;
      else if (pick < 71) op = fdat_pkg::OP_CLEAR;
      else if (pick < 80) op = fdat_pkg::OP_READ;
      else if (pick < 93) op = fdat_pkg::OP_DEGREE;
      else if (pick < 96) op = fdat_pkg::OP_SPARE_LO;
      else op = fdat_pkg::OP_SPARE_HI;
      pick = $urandom_range(0, 99);
      if (pick < 85) node = $urandom_range(0, 5);
      else if (pick < 95) node = $urandom_range(0, 1100);
      else node = $urandom_range(0, 65535);
      pick = $urandom_range(0, 99);
      if (pick < 80) other = $urandom_range(0, 7);
      else if (pick < 90) other = $urandom_range(0, 1100);
      else other = $urandom_range(0, 65535);
      send_request(op, node, other);
   endtask

   task automatic test_random_traffic();
      for (int p = 0; p < 4; p++) begin
         case (p)
            0: begin set_nodes(1024); set_limit(32); end
            1: begin set_nodes($urandom_range(2, 8)); set_limit(3); end
            2: begin set_nodes($urandom_range(1, 1024)); set_limit($urandom_range(1, 12)); end
            default: begin set_nodes(6); set_limit(8); end
         endcase
         quiet = (p == 3);
         for (int i = 0; i < 120; i++) begin
            random_request();
            if (i == 60) wait_idle();
         end
         quiet = 1'b0;
      end
   endtask

   initial begin
      for (int i = 0; i < NODES; i++) node_deg[i] = 0;
      edge_total = 0;
      nodes_cfg = fdat_pkg::NODES_RESET;
      limit_cfg = fdat_pkg::LIMIT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_ops();
      test_degree_limit();
      test_node_count();
      test_random_traffic();
      wait_idle();
      repeat (50) @(posedge clock);
      if (errors == 0) $display("Verification passed");
      else $display("Verification failed");
      $finish;
   end
endmodule
